@@ rtl/coprocessor_dma_control_registers_macros.svh @@
// Assertion macros shared by the coprocessor DMA register block.
`ifndef COPROCESSOR_DMA_CONTROL_REGISTERS_MACROS_SVH
`define COPROCESSOR_DMA_CONTROL_REGISTERS_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define CDCR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define CDCR_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cdcr_pkg.sv @@
// Shared types and constants of the coprocessor DMA register block.
`default_nettype none

package cdcr_pkg;

    localparam int ADDR_W     = 26;
    localparam int LEN_W      = 32;
    localparam int STATUS_W   = 15;
    localparam int PC_W       = 12;
    localparam int MEM_W      = 24;
    localparam int ROWB_W     = 13;
    localparam int ROWS_W     = 9;
    localparam int SKIP_W     = 12;
    localparam int COPY_W     = 13;
    localparam int TOTAL_W    = ROWB_W + ROWS_W;

    localparam logic [LEN_W-1:0]    LEN_MASK        = 32'hFF8F_FFFF;
    localparam logic [LEN_W-1:0]    SKIP_KEEP       = 32'hFF80_0000;
    localparam logic [LEN_W-1:0]    LEN_IDLE        = 32'h0000_0FF8;
    localparam logic [MEM_W-1:0]    MEM_BYTES_RESET = 24'd8388608;
    localparam logic [STATUS_W-1:0] STATUS_RESET    = 15'h0001;

    // status bit positions
    localparam int ST_HALT     = 0;
    localparam int ST_BROKE    = 1;
    localparam int ST_BUSY     = 2;
    localparam int ST_FULL     = 3;
    localparam int ST_INTBREAK = 6;
    localparam int ST_SIG0     = 7;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        REG_SPADDR  = 3'd0,
        REG_RAMADDR = 3'd1,
        REG_RDLEN   = 3'd2,
        REG_WRLEN   = 3'd3,
        REG_STATUS  = 3'd4,
        REG_FULL    = 3'd5,
        REG_BUSY    = 3'd6,
        REG_SEM     = 3'd7
    } reg_idx_t;

    // one bus access or event word
    typedef struct packed {
        op_t             op;
        logic            is_pc_access;
        reg_idx_t        reg_index;
        logic [31:0]     write_word;
    } item_t;

    // decoded DMA length and clipped byte count
    typedef struct packed {
        logic [ROWB_W-1:0] row_bytes;
        logic [ROWS_W-1:0] rows;
        logic [SKIP_W-1:0] skip;
        logic [COPY_W-1:0] copy_bytes;
    } dma_cmd_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [COPY_W-1:0] dma_copy_bytes;
        logic [SKIP_W-1:0] dma_skip;
        logic [ROWS_W-1:0] dma_rows;
        logic [ROWB_W-1:0] dma_row_bytes;
        logic [ADDR_W-1:0] dma_local_addr;
        logic [ADDR_W-1:0] dma_main_addr;
        logic              dma_to_main;
        logic              dma_start;
        logic              single_step;
        logic              clear_interrupt;
        logic              raise_interrupt;
        logic [31:0]       read_word;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/cdcr_in_stage.sv @@
// Input register with the local-address quotient estimate.
`default_nettype none

module cdcr_in_stage #(
    parameter int LOCAL_MEM_BYTES = 4096
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,   // write_word
    input  wire logic [5:0]           s_tuser,   // op[1:0], is_pc_access[2], reg_index[5:3]
    input  wire logic                 take,
    output logic                      item_valid,
    output cdcr_pkg::item_t           item,
    output logic [cdcr_pkg::ADDR_W-$clog2(LOCAL_MEM_BYTES)+1:0] q_est
);

    localparam int AW = cdcr_pkg::ADDR_W;
    localparam int QW = AW - $clog2(LOCAL_MEM_BYTES) + 2;
    localparam logic [QW-1:0] RECIP = QW'((64'd1 << AW) / LOCAL_MEM_BYTES);

    logic                 valid_reg;
    cdcr_pkg::item_t      item_reg;
    logic [QW-1:0]        q_reg;
    logic [AW-1:0]        s_addr;
    logic [AW+QW-1:0]     q_full;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;
    assign q_est      = q_reg;

    // floor(addr / LOCAL_MEM_BYTES), low by at most one
    assign s_addr = {s_tdata[AW-1:3], 3'b000};
    assign q_full = {{QW{1'b0}}, s_addr} * {{AW{1'b0}}, RECIP};

    // word occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op           <= cdcr_pkg::op_t'(s_tuser[1:0]);
            item_reg.is_pc_access <= s_tuser[2];
            item_reg.reg_index    <= cdcr_pkg::reg_idx_t'(s_tuser[5:3]);
            item_reg.write_word   <= s_tdata;
            q_reg                 <= q_full[AW+QW-1:AW];
        end
    end

endmodule

`default_nettype wire

@@ rtl/cdcr_dma_calc.sv @@
// DMA length decode and byte count clipping to both memory ends.
`default_nettype none

module cdcr_dma_calc #(
    parameter int LOCAL_MEM_BYTES = 4096
) (
    input  wire logic [cdcr_pkg::LEN_W-1:0]              len,
    input  wire logic [cdcr_pkg::ADDR_W-1:0]             main_addr,
    input  wire logic [$clog2(LOCAL_MEM_BYTES):0]        local_rem,
    input  wire logic [cdcr_pkg::MEM_W-1:0]              mem_bytes,
    output cdcr_pkg::dma_cmd_t                           cmd
);

    localparam int LW = $clog2(LOCAL_MEM_BYTES) + 1;
    localparam int MW = cdcr_pkg::MEM_W;
    localparam logic [LW-1:0] LOC_BYTES = LW'(LOCAL_MEM_BYTES);

    logic [cdcr_pkg::ROWB_W-1:0]  row_bytes;
    logic [cdcr_pkg::ROWS_W-1:0]  rows;
    logic [cdcr_pkg::TOTAL_W-1:0] total;
    logic [MW-1:0]                to_main;
    logic [LW-1:0]                to_local;
    logic [MW-1:0]                clip_a;
    logic [MW-1:0]                clip_b;

    // row geometry
    assign row_bytes = {1'b0, len[11:3], 3'b000} + cdcr_pkg::ROWB_W'(8);
    assign rows      = {1'b0, len[19:12]} + cdcr_pkg::ROWS_W'(1);
    assign total     = rows * row_bytes;

    // bytes left before each memory end
    assign to_main  = ({2'b00, mem_bytes} > main_addr) ? (mem_bytes - main_addr[MW-1:0])
                                                       : '0;
    assign to_local = LOC_BYTES - local_rem;

    // smallest of the three
    assign clip_a = (MW'(total) > to_main) ? to_main : MW'(total);
    assign clip_b = (clip_a > MW'(to_local)) ? MW'(to_local) : clip_a;

    assign cmd.row_bytes  = row_bytes;
    assign cmd.rows       = rows;
    assign cmd.skip       = len[31:20];
    assign cmd.copy_bytes = clip_b[cdcr_pkg::COPY_W-1:0];

endmodule

`default_nettype wire

@@ rtl/cdcr_core.sv @@
// Register state, access decode, DMA launch control and result register.
`default_nettype none
`include "coprocessor_dma_control_registers_macros.svh"

module cdcr_core #(
    parameter int LOCAL_MEM_BYTES = 4096
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [cdcr_pkg::MEM_W-1:0]  cfg_wr_data,
    input  wire logic                        advance,
    input  wire cdcr_pkg::item_t             item,
    input  wire logic [cdcr_pkg::ADDR_W-$clog2(LOCAL_MEM_BYTES)+1:0] q_est,
    input  wire logic                        m_tready,
    output logic                             m_valid,
    output cdcr_pkg::result_t                result
);

    localparam int AW = cdcr_pkg::ADDR_W;
    localparam int QW = AW - $clog2(LOCAL_MEM_BYTES) + 2;
    localparam int LW = $clog2(LOCAL_MEM_BYTES) + 1;
    localparam int SW = cdcr_pkg::STATUS_W;
    localparam logic [AW-1:0] LOC_BYTES = AW'(LOCAL_MEM_BYTES);

    // architectural state
    logic [cdcr_pkg::PC_W-1:0]   pc_reg, pc_next;
    logic [AW-1:0]               local_reg, local_next;
    logic [LW-1:0]               local_rem_reg, local_rem_next;
    logic [AW-1:0]               main_reg, main_next;
    logic [31:0]                 rl_reg, rl_next;
    logic [31:0]                 wl_reg, wl_next;
    logic [SW-1:0]               status_reg, status_next;
    logic [31:0]                 sem_reg, sem_next;
    logic                        active_reg, active_next;
    logic                        adir_reg, adir_next;
    logic                        pending_reg, pending_next;
    logic                        pdir_reg, pdir_next;
    logic [31:0]                 blen_reg [2];
    logic [31:0]                 blen_next [2];
    logic                        step_reg, step_next;
    logic [cdcr_pkg::MEM_W-1:0]  mem_bytes_reg;

    logic                        m_valid_reg;
    cdcr_pkg::result_t           res_reg, res_next;

    // launch request to the calculator
    logic                        start;
    logic                        start_dir;
    logic [31:0]                 start_len;
    cdcr_pkg::dma_cmd_t          cmd;

    // helpers
    logic [31:0]                 w;
    logic [31:0]                 wr_len_v;
    logic                        wr_dir;
    logic [31:0]                 act_len;
    logic [31:0]                 rd_len;
    logic [31:0]                 fin_idle_len;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               q_prod;
    logic [AW-1:0]               rem0;
    logic [AW-1:0]               rem1;

    assign w            = item.write_word;
    assign wr_len_v     = w & cdcr_pkg::LEN_MASK;
    assign wr_dir       = (item.reg_index == cdcr_pkg::REG_WRLEN);
    assign act_len      = adir_reg ? wl_reg : rl_reg;
    assign rd_len       = active_reg ? act_len
                                     : ((item.reg_index == cdcr_pkg::REG_RDLEN) ? rl_reg
                                                                                : wl_reg);
    assign fin_idle_len = cdcr_pkg::LEN_IDLE | (act_len & cdcr_pkg::SKIP_KEEP);

    // local address modulo local memory size, one correction step
    assign wr_addr = {w[AW-1:3], 3'b000};
    assign q_prod  = AW'({{(AW-QW){1'b0}}, q_est} * LOC_BYTES);
    assign rem0    = wr_addr - q_prod;
    assign rem1    = (rem0 >= LOC_BYTES) ? (rem0 - LOC_BYTES) : rem0;

    cdcr_dma_calc #(
        .LOCAL_MEM_BYTES (LOCAL_MEM_BYTES)
    ) u_dma_calc (
        .len       (start_len),
        .main_addr (main_reg),
        .local_rem (local_rem_reg),
        .mem_bytes (mem_bytes_reg),
        .cmd       (cmd)
    );

    // next state and result for the word in the input register
    always_comb begin
        pc_next        = pc_reg;
        local_next     = local_reg;
        local_rem_next = local_rem_reg;
        main_next      = main_reg;
        rl_next        = rl_reg;
        wl_next        = wl_reg;
        status_next    = status_reg;
        sem_next       = sem_reg;
        active_next    = active_reg;
        adir_next      = adir_reg;
        pending_next   = pending_reg;
        pdir_next      = pdir_reg;
        blen_next[0]   = blen_reg[0];
        blen_next[1]   = blen_reg[1];
        step_next      = step_reg;
        res_next       = '0;
        start          = 1'b0;
        start_dir      = 1'b0;
        start_len      = '0;

        unique case (item.op)
            cdcr_pkg::OP_READ: begin
                if (item.is_pc_access) begin
                    res_next.read_word = {{(32-cdcr_pkg::PC_W){1'b0}}, pc_reg};
                end else begin
                    unique case (item.reg_index)
                        cdcr_pkg::REG_SPADDR:  res_next.read_word = {{(32-AW){1'b0}}, local_reg};
                        cdcr_pkg::REG_RAMADDR: res_next.read_word = {{(32-AW){1'b0}}, main_reg};
                        cdcr_pkg::REG_RDLEN,
                        cdcr_pkg::REG_WRLEN:   res_next.read_word = {rd_len[31:3], 3'b000};
                        cdcr_pkg::REG_STATUS:  res_next.read_word = {{(32-SW){1'b0}}, status_reg};
                        cdcr_pkg::REG_FULL: begin
                            res_next.read_word = {31'b0, status_reg[cdcr_pkg::ST_FULL]};
                        end
                        cdcr_pkg::REG_BUSY: begin
                            res_next.read_word = {31'b0, status_reg[cdcr_pkg::ST_BUSY]};
                        end
                        cdcr_pkg::REG_SEM: begin
                            res_next.read_word = sem_reg;
                            sem_next           = sem_reg | 32'd1;
                        end
                        default: ;
                    endcase
                end
            end
            cdcr_pkg::OP_WRITE: begin
                if (item.is_pc_access) begin
                    pc_next = {w[cdcr_pkg::PC_W-1:2], 2'b00};
                end else begin
                    unique case (item.reg_index)
                        cdcr_pkg::REG_SPADDR: begin
                            local_next     = wr_addr;
                            local_rem_next = rem1[LW-1:0];
                        end
                        cdcr_pkg::REG_RAMADDR: main_next = wr_addr;
                        cdcr_pkg::REG_RDLEN,
                        cdcr_pkg::REG_WRLEN: begin
                            if (active_reg) begin
                                // queue behind the running transfer
                                blen_next[wr_dir]              = wr_len_v;
                                pending_next                   = 1'b1;
                                pdir_next                      = wr_dir;
                                status_next[cdcr_pkg::ST_FULL] = 1'b1;
                            end else begin
                                if (wr_dir) begin
                                    wl_next = wr_len_v;
                                end else begin
                                    rl_next = wr_len_v;
                                end
                                start     = 1'b1;
                                start_dir = wr_dir;
                                start_len = wr_len_v;
                            end
                        end
                        cdcr_pkg::REG_STATUS: begin
                            // set/clear pairs, a pair with both or neither bit is a no-op
                            if (w[0] && !w[1]) status_next[cdcr_pkg::ST_HALT] = 1'b0;
                            else if (!w[0] && w[1]) status_next[cdcr_pkg::ST_HALT] = 1'b1;
                            if (w[2]) status_next[cdcr_pkg::ST_BROKE] = 1'b0;
                            res_next.clear_interrupt = w[3] && !w[4];
                            res_next.raise_interrupt = !w[3] && w[4];
                            if (w[5] && !w[6]) step_next = 1'b0;
                            else if (!w[5] && w[6]) step_next = 1'b1;
                            if (w[7] && !w[8]) status_next[cdcr_pkg::ST_INTBREAK] = 1'b0;
                            else if (!w[7] && w[8]) status_next[cdcr_pkg::ST_INTBREAK] = 1'b1;
                            for (int i = 0; i < 8; i++) begin
                                if (w[9+2*i] && !w[10+2*i]) begin
                                    status_next[cdcr_pkg::ST_SIG0+i] = 1'b0;
                                end else if (!w[9+2*i] && w[10+2*i]) begin
                                    status_next[cdcr_pkg::ST_SIG0+i] = 1'b1;
                                end
                            end
                        end
                        cdcr_pkg::REG_SEM: sem_next = w;
                        default: ;
                    endcase
                end
            end
            cdcr_pkg::OP_FINISH: begin
                if (active_reg) begin
                    if (pending_reg) begin
                        // hand over to the queued transfer in its own direction
                        pending_next                   = 1'b0;
                        status_next[cdcr_pkg::ST_FULL] = 1'b0;
                        rl_next                        = blen_reg[pdir_reg];
                        wl_next                        = blen_reg[pdir_reg];
                        start                          = 1'b1;
                        start_dir                      = pdir_reg;
                        start_len                      = blen_reg[pdir_reg];
                    end else begin
                        active_next                    = 1'b0;
                        status_next[cdcr_pkg::ST_BUSY] = 1'b0;
                        rl_next                        = fin_idle_len;
                        wl_next                        = fin_idle_len;
                    end
                end
            end
            default: ;
        endcase

        // DMA launch
        if (start) begin
            active_next                    = 1'b1;
            adir_next                      = start_dir;
            status_next[cdcr_pkg::ST_BUSY] = 1'b1;
            res_next.dma_start             = 1'b1;
            res_next.dma_to_main           = start_dir;
            res_next.dma_main_addr         = main_reg;
            res_next.dma_local_addr        = local_reg;
            res_next.dma_row_bytes         = cmd.row_bytes;
            res_next.dma_rows              = cmd.rows;
            res_next.dma_skip              = cmd.skip;
            res_next.dma_copy_bytes        = cmd.copy_bytes;
        end

        res_next.single_step = step_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= '0;
            local_reg     <= '0;
            local_rem_reg <= '0;
            main_reg      <= '0;
            rl_reg        <= '0;
            wl_reg        <= '0;
            status_reg    <= cdcr_pkg::STATUS_RESET;
            sem_reg       <= '0;
            active_reg    <= 1'b0;
            adir_reg      <= 1'b0;
            pending_reg   <= 1'b0;
            pdir_reg      <= 1'b0;
            blen_reg[0]   <= '0;
            blen_reg[1]   <= '0;
            step_reg      <= 1'b0;
        end else if (advance) begin
            pc_reg        <= pc_next;
            local_reg     <= local_next;
            local_rem_reg <= local_rem_next;
            main_reg      <= main_next;
            rl_reg        <= rl_next;
            wl_reg        <= wl_next;
            status_reg    <= status_next;
            sem_reg       <= sem_next;
            active_reg    <= active_next;
            adir_reg      <= adir_next;
            pending_reg   <= pending_next;
            pdir_reg      <= pdir_next;
            blen_reg[0]   <= blen_next[0];
            blen_reg[1]   <= blen_next[1];
            step_reg      <= step_next;
        end
    end

    // memory size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_bytes_reg <= cdcr_pkg::MEM_BYTES_RESET;
        end else if (cfg_wr_en) begin
            mem_bytes_reg <= cfg_wr_data;
        end
    end

    // result word occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign result  = res_reg;

    // checks
    `CDCR_ASSERT_IMP(a_pending_needs_active, aclk, aresetn, pending_reg, active_reg,
        "pending DMA without an active one")
    `CDCR_ASSERT_IMP(a_flags_track_state, aclk, aresetn, 1'b1,
        (status_reg[cdcr_pkg::ST_BUSY] == active_reg) &&
        (status_reg[cdcr_pkg::ST_FULL] == pending_reg),
        "busy/full status bits out of step with transfer state")
    `CDCR_ASSERT_IMP(a_start_marks_active, aclk, aresetn, m_valid_reg && res_reg.dma_start,
        active_reg, "DMA start result while no transfer is active")
    `CDCR_ASSERT_NXT(a_sem_read_sets, aclk, aresetn,
        advance && (item.op == cdcr_pkg::OP_READ) && !item.is_pc_access &&
        (item.reg_index == cdcr_pkg::REG_SEM),
        sem_reg[0], "semaphore bit not set after read")

endmodule

`default_nettype wire

@@ rtl/coprocessor_dma_control_registers.sv @@
// Top level of the coprocessor DMA register block.
`default_nettype none

// Register block of a coprocessor interface. Each input word is a register
// read, a register write (eight registers by index, or the program counter)
// or a DMA-finished event; each gives exactly one result word carrying read
// data, interrupt requests, the step flag and, when a DMA begins, its
// command with the byte count clipped to the ends of main and local memory.
// One word is taken every clock cycle unless the result register is held; a
// word passes the input register, then the result register, with all decode,
// the row-count multiply and the clipping compares done in one pass between
// them. The local-address modulo is split around the input register so its
// two multiplies never stand in the same path. No clearing pass after reset. The user
// writes the main memory size through cfg_wr_en/cfg_wr_data while idle; the block does not check.

module coprocessor_dma_control_registers #(
    parameter int LOCAL_MEM_BYTES = 4096
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [cdcr_pkg::MEM_W-1:0]  cfg_wr_data,  // main_memory_bytes
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [31:0]                 s_tdata,      // write_word
    input  wire logic [5:0]                  s_tuser,      // op[1:0], is_pc_access[2], reg_index[5:3]
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // read_word[31:0], raise_interrupt[32], clear_interrupt[33], single_step[34],
    // dma_start[35], dma_to_main[36], dma_main_addr[62:37], dma_local_addr[88:63],
    // dma_row_bytes[101:89], dma_rows[110:102], dma_skip[122:111],
    // dma_copy_bytes[135:123]
    output logic [135:0]                     m_tdata
);

    localparam int QW = cdcr_pkg::ADDR_W - $clog2(LOCAL_MEM_BYTES) + 2;

    logic               item_valid;
    cdcr_pkg::item_t    item;
    logic [QW-1:0]      q_est;
    logic               advance;
    cdcr_pkg::result_t  result;

    // a word moves on when the result slot is free or being emptied
    assign advance = item_valid && (!m_tvalid || m_tready);

    cdcr_in_stage #(
        .LOCAL_MEM_BYTES (LOCAL_MEM_BYTES)
    ) u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item),
        .q_est      (q_est)
    );

    cdcr_core #(
        .LOCAL_MEM_BYTES (LOCAL_MEM_BYTES)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .item        (item),
        .q_est       (q_est),
        .m_tready    (m_tready),
        .m_valid     (m_tvalid),
        .result      (result)
    );

    assign m_tdata = result;

endmodule

`default_nettype wire
